/* hdl/scf_pkg.sv */
// Shared types and constants for the sphere frustum cull block.
package scf_pkg;

   localparam int COORD_BITS = 32;
   localparam int HALF_W     = 32;
   localparam int CSR_W      = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int FRAC_BITS  = 16;
   localparam int RAD_W      = COORD_BITS - 1;
   localparam int CPROD_W    = COORD_BITS + HALF_W;
   localparam int BPROD_W    = HALF_W + RAD_W;
   localparam int CMP_W      = CPROD_W + 2;
   localparam int DEP_W      = ((COORD_BITS > HALF_W) ? COORD_BITS : HALF_W) + 2;
   localparam int MASK_W     = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOPES_LR  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOPES_TB  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTHS_LR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTHS_TB = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_FAR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ORTHO_X    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ORTHO_Y    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_PROJ_MODE  = 3'd7;

   localparam logic [1:0] PARENT_VISIBLE = 2'd0;
   localparam logic [1:0] PARENT_CULLED  = 2'd1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] center_x;
      logic signed [COORD_BITS-1:0] center_depth;
      logic signed [COORD_BITS-1:0] center_z;
      logic        [RAD_W-1:0]      radius;
      logic        [1:0]            parent_state;
   } req_type;

   typedef struct packed {
      logic              outside;
      logic [MASK_W-1:0] clip_mask;
   } rsp_type;

   typedef struct packed {
      logic signed [HALF_W-1:0] slope_l;
      logic signed [HALF_W-1:0] slope_r;
      logic signed [HALF_W-1:0] slope_t;
      logic signed [HALF_W-1:0] slope_b;
      logic        [HALF_W-1:0] len_l;
      logic        [HALF_W-1:0] len_r;
      logic        [HALF_W-1:0] len_t;
      logic        [HALF_W-1:0] len_b;
      logic signed [HALF_W-1:0] near_depth;
      logic signed [HALF_W-1:0] far_depth;
      logic signed [HALF_W-1:0] ortho_left;
      logic signed [HALF_W-1:0] ortho_right;
      logic signed [HALF_W-1:0] ortho_upper;
      logic signed [HALF_W-1:0] ortho_lower;
      logic                     ortho_mode;
   } cfg_type;

   typedef struct packed {
      logic signed [CPROD_W-1:0]    c_l;
      logic signed [CPROD_W-1:0]    c_r;
      logic signed [CPROD_W-1:0]    c_t;
      logic signed [CPROD_W-1:0]    c_b;
      logic        [BPROD_W-1:0]    b_l;
      logic        [BPROD_W-1:0]    b_r;
      logic        [BPROD_W-1:0]    b_t;
      logic        [BPROD_W-1:0]    b_b;
      logic signed [COORD_BITS-1:0] center_x;
      logic signed [COORD_BITS-1:0] center_depth;
      logic signed [COORD_BITS-1:0] center_z;
      logic        [RAD_W-1:0]      radius;
      logic        [1:0]            parent_state;
   } prod_type;

endpackage

/* hdl/sphere_frustum_cull.sv */
// Top level of the sphere frustum cull block.
//
// Request channel (req_*): one bounding sphere per beat, center in camera
// space (depth on y), radius and the parent verdict. Response channel
// (rsp_*): one beat per request, in order: outside flag and the mask of
// planes crossed (zero whenever outside is set).
// Configuration (csr_*): one 64-bit register written per cycle with
// csr_wr_en; write only while no request is in flight.
// An accepted request passes the input register, loaded at the accept edge,
// then the product register holding the eight slope and radius products,
// then the response register.
// Throughput: one sphere per cycle unless rsp_ready stalls; each of the three registers
// holds its beat only while the stage after it is full and stalled.
// When rsp_ready is low the response holds; the two upstream stages keep
// filling, so req_ready drops only once all three are occupied.
// Reset clears all pipeline valids and all configuration registers to zero.
module sphere_frustum_cull (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  scf_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output scf_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [scf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [scf_pkg::CSR_W-1:0]     csr_wdata
);

   scf_pkg::cfg_type  cfg;
   scf_pkg::prod_type prod_data;
   logic              prod_valid, prod_ready;

   scf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   scf_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .cfg        (cfg),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod_data  (prod_data)
   );

   scf_decide u_decide (
      .clock      (clock),
      .reset      (reset),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod_data  (prod_data),
      .cfg        (cfg),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

/* hdl/scf_csr.sv */
// Configuration register file for the sphere frustum cull block.
module scf_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [scf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [scf_pkg::CSR_W-1:0]      csr_wdata,
   output scf_pkg::cfg_type               cfg
);

   localparam int HW = scf_pkg::HALF_W;

   scf_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            scf_pkg::CSR_SLOPES_LR: begin
               cfg_in.slope_l = csr_wdata[HW-1:0];
               cfg_in.slope_r = csr_wdata[2*HW-1:HW];
            end
            scf_pkg::CSR_SLOPES_TB: begin
               cfg_in.slope_t = csr_wdata[HW-1:0];
               cfg_in.slope_b = csr_wdata[2*HW-1:HW];
            end
            scf_pkg::CSR_LENGTHS_LR: begin
               cfg_in.len_l = csr_wdata[HW-1:0];
               cfg_in.len_r = csr_wdata[2*HW-1:HW];
            end
            scf_pkg::CSR_LENGTHS_TB: begin
               cfg_in.len_t = csr_wdata[HW-1:0];
               cfg_in.len_b = csr_wdata[2*HW-1:HW];
            end
            scf_pkg::CSR_NEAR_FAR: begin
               cfg_in.near_depth = csr_wdata[HW-1:0];
               cfg_in.far_depth  = csr_wdata[2*HW-1:HW];
            end
            scf_pkg::CSR_ORTHO_X: begin
               cfg_in.ortho_left  = csr_wdata[HW-1:0];
               cfg_in.ortho_right = csr_wdata[2*HW-1:HW];
            end
            scf_pkg::CSR_ORTHO_Y: begin
               cfg_in.ortho_upper = csr_wdata[HW-1:0];
               cfg_in.ortho_lower = csr_wdata[2*HW-1:HW];
            end
            scf_pkg::CSR_PROJ_MODE: begin
               cfg_in.ortho_mode = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/scf_mul.sv */
// Input register and product stage: plane offsets and radius terms.
module scf_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  scf_pkg::req_type   req_data,
   input  scf_pkg::cfg_type   cfg,
   output logic               prod_valid,
   input  logic               prod_ready,
   output scf_pkg::prod_type  prod_data
);

   localparam int CPW = scf_pkg::CPROD_W;
   localparam int BPW = scf_pkg::BPROD_W;

   logic              in_valid_ff, in_valid_in;
   scf_pkg::req_type  in_data_ff;
   logic              prod_valid_ff, prod_valid_in;
   scf_pkg::prod_type prod_ff, prod_in;
   logic              in_ready;

   assign in_ready    = !prod_valid_ff || prod_ready;
   assign req_ready   = !in_valid_ff || in_ready;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;
   assign prod_valid_in = in_ready ? in_valid_ff : prod_valid_ff;

   always_comb begin
      prod_in.c_l = CPW'($signed(in_data_ff.center_depth)) * CPW'($signed(cfg.slope_l));
      prod_in.c_r = CPW'($signed(in_data_ff.center_depth)) * CPW'($signed(cfg.slope_r));
      prod_in.c_t = CPW'($signed(in_data_ff.center_depth)) * CPW'($signed(cfg.slope_t));
      prod_in.c_b = CPW'($signed(in_data_ff.center_depth)) * CPW'($signed(cfg.slope_b));
      prod_in.b_l = BPW'(cfg.len_l) * BPW'(in_data_ff.radius);
      prod_in.b_r = BPW'(cfg.len_r) * BPW'(in_data_ff.radius);
      prod_in.b_t = BPW'(cfg.len_t) * BPW'(in_data_ff.radius);
      prod_in.b_b = BPW'(cfg.len_b) * BPW'(in_data_ff.radius);
      prod_in.center_x     = in_data_ff.center_x;
      prod_in.center_depth = in_data_ff.center_depth;
      prod_in.center_z     = in_data_ff.center_z;
      prod_in.radius       = in_data_ff.radius;
      prod_in.parent_state = in_data_ff.parent_state;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         prod_valid_ff <= prod_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_data_ff <= req_data;
      end
      if (in_ready) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_valid = prod_valid_ff;
   assign prod_data  = prod_ff;

endmodule

/* hdl/scf_decide.sv */
// Plane comparisons, verdict selection and result register.
module scf_decide (
   input  logic               clock,
   input  logic               reset,
   input  logic               prod_valid,
   output logic               prod_ready,
   input  scf_pkg::prod_type  prod_data,
   input  scf_pkg::cfg_type   cfg,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output scf_pkg::rsp_type   rsp_data
);

   localparam int CW = scf_pkg::CMP_W;
   localparam int DW = scf_pkg::DEP_W;

   logic             rsp_valid_ff, rsp_valid_in;
   scf_pkg::rsp_type rsp_ff, rsp_in;

   logic signed [CW-1:0] xq, zq, cl, cr, ct, cb, bl, br, bt, bb;
   logic signed [DW-1:0] xd, yd, zd, rd, near_d, far_d;
   logic signed [DW-1:0] left_d, right_d, upper_d, lower_d;
   logic out_r, out_l, out_t, out_b, out_n, out_f;
   logic [scf_pkg::MASK_W-1:0] mask;
   logic in_box;

   assign prod_ready   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = prod_ready ? prod_valid : rsp_valid_ff;

   always_comb begin
      xq = CW'($signed(prod_data.center_x)) <<< scf_pkg::FRAC_BITS;
      zq = CW'($signed(prod_data.center_z)) <<< scf_pkg::FRAC_BITS;
      cl = CW'($signed(prod_data.c_l));
      cr = CW'($signed(prod_data.c_r));
      ct = CW'($signed(prod_data.c_t));
      cb = CW'($signed(prod_data.c_b));
      bl = CW'(prod_data.b_l);
      br = CW'(prod_data.b_r);
      bt = CW'(prod_data.b_t);
      bb = CW'(prod_data.b_b);

      xd      = DW'($signed(prod_data.center_x));
      yd      = DW'($signed(prod_data.center_depth));
      zd      = DW'($signed(prod_data.center_z));
      rd      = DW'(prod_data.radius);
      near_d  = DW'($signed(cfg.near_depth));
      far_d   = DW'($signed(cfg.far_depth));
      left_d  = DW'($signed(cfg.ortho_left));
      right_d = DW'($signed(cfg.ortho_right));
      upper_d = DW'($signed(cfg.ortho_upper));
      lower_d = DW'($signed(cfg.ortho_lower));

      // early rejects; once any fires the crossing mask is dropped
      out_r = cr < (xq - br);
      out_l = (xq + bl) < cl;
      out_t = ct < (zq - bt);
      out_b = (zq + bb) < cb;
      out_n = (yd + rd) < near_d;
      out_f = far_d < (yd - rd);

      mask[0] = (xq - bl) < cl;
      mask[1] = cr < (xq + br);
      mask[2] = (zq - bb) < cb;
      mask[3] = ct < (zq + bt);
      mask[4] = (yd - rd) < near_d;
      mask[5] = far_d < (yd + rd);

      in_box = (left_d < xd) && (xd < right_d) && (zd < upper_d) && (lower_d < zd) &&
               (near_d < yd) && (yd < far_d);

      rsp_in = '0;
      case (prod_data.parent_state)
         scf_pkg::PARENT_VISIBLE: begin
            rsp_in.outside = 1'b0;
         end
         scf_pkg::PARENT_CULLED: begin
            rsp_in.outside = 1'b1;
         end
         default: begin
            if (cfg.ortho_mode) begin
               rsp_in.outside = !in_box;
            end else if (out_r || out_l || out_t || out_b || out_n || out_f) begin
               rsp_in.outside = 1'b1;
            end else begin
               rsp_in.clip_mask = mask;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hdl/scf_checker.sv */
// Port-level assertions for the sphere frustum cull block, with bind.
module scf_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input scf_pkg::rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   a_outside_no_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.outside |-> rsp_data.clip_mask == '0)
      else $error("outside beat carries a clip mask");

   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   a_sink_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while response side is ready");

endmodule

bind sphere_frustum_cull scf_checker u_scf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
